/* rtl/core/assert_macros.svh */
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising clock edge out of reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication checked on every rising clock edge out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/rpbf_pkg.sv */
// types, codes and rounding helpers for the relative pose core
`timescale 1ns / 1ps
`default_nettype none

package rpbf_pkg;

    // measurement kinds carried in tuser
    localparam logic [2:0] FUNC_VEH_POSE = 3'd0;
    localparam logic [2:0] FUNC_VEH_VEL  = 3'd1;
    localparam logic [2:0] FUNC_PAY_POS  = 3'd2;
    localparam logic [2:0] FUNC_PAY_VEL  = 3'd3;
    localparam logic [2:0] FUNC_TICK     = 3'd4;

    localparam int VEC_W   = 32;
    localparam int QUAT_W  = 16;
    localparam int ENTRY_W = 28;
    localparam int DIFF_W  = 33;
    localparam int ACC_W   = 64;
    localparam int CNT_W   = 5;

    // accumulator start value of a multiply
    localparam logic [1:0] MAC_INIT_KEEP = 2'd0;
    localparam logic [1:0] MAC_INIT_ZERO = 2'd1;
    localparam logic [1:0] MAC_INIT_ONE  = 2'd2;

    // quaternion component selects
    localparam logic [1:0] Q_W = 2'd0;
    localparam logic [1:0] Q_X = 2'd1;
    localparam logic [1:0] Q_Y = 2'd2;
    localparam logic [1:0] Q_Z = 2'd3;

    // index of the sign bit of the serial multiplier operand
    localparam logic [CNT_W-1:0] QUAT_LAST_BIT  = 5'd15;
    localparam logic [CNT_W-1:0] ENTRY_LAST_BIT = 5'd27;

    localparam logic [4:0] ENTRY_LAST_STEP = 5'd17;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [1:0]       init;
        logic [CNT_W-1:0] last_bit;
    } mac_cmd_t;

    typedef struct packed {
        logic [1:0] a_sel;
        logic [1:0] b_sel;
        logic       neg;
        logic       one;
    } quat_step_t;

    // two products per matrix entry, entries in row-major order
    function automatic quat_step_t quat_step(input logic [4:0] step);
        quat_step_t s;
        case (step)
            5'd0:    s = '{Q_Y, Q_Y, 1'b1, 1'b1};
            5'd1:    s = '{Q_Z, Q_Z, 1'b1, 1'b0};
            5'd2:    s = '{Q_X, Q_Y, 1'b0, 1'b0};
            5'd3:    s = '{Q_W, Q_Z, 1'b1, 1'b0};
            5'd4:    s = '{Q_X, Q_Z, 1'b0, 1'b0};
            5'd5:    s = '{Q_W, Q_Y, 1'b0, 1'b0};
            5'd6:    s = '{Q_X, Q_Y, 1'b0, 1'b0};
            5'd7:    s = '{Q_W, Q_Z, 1'b0, 1'b0};
            5'd8:    s = '{Q_X, Q_X, 1'b1, 1'b1};
            5'd9:    s = '{Q_Z, Q_Z, 1'b1, 1'b0};
            5'd10:   s = '{Q_Y, Q_Z, 1'b0, 1'b0};
            5'd11:   s = '{Q_W, Q_X, 1'b1, 1'b0};
            5'd12:   s = '{Q_X, Q_Z, 1'b0, 1'b0};
            5'd13:   s = '{Q_W, Q_Y, 1'b1, 1'b0};
            5'd14:   s = '{Q_Y, Q_Z, 1'b0, 1'b0};
            5'd15:   s = '{Q_W, Q_X, 1'b0, 1'b0};
            5'd16:   s = '{Q_X, Q_X, 1'b1, 1'b1};
            5'd17:   s = '{Q_Y, Q_Y, 1'b1, 1'b0};
            default: s = '{Q_W, Q_W, 1'b0, 1'b0};
        endcase
        return s;
    endfunction

    // q28 to q24, round half up, saturate to 28 bits
    function automatic logic [ENTRY_W-1:0] entry_round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        s = (v + 64'sd8) >>> 4;
        if (s > 64'sd134217727) begin
            return 28'h7FF_FFFF;
        end else if (s < -64'sd134217728) begin
            return 28'h800_0000;
        end else begin
            return s[ENTRY_W-1:0];
        end
    endfunction

    // q40 to q16.16, round half up, saturate to 32 bits
    function automatic logic [VEC_W-1:0] out_round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        s = (v + 64'sd8388608) >>> 24;
        if (s > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (s < -64'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return s[VEC_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rpbf_mac.sv */
// bit-serial signed multiply-accumulate, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module rpbf_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rpbf_pkg::mac_cmd_t                  cmd,
    input  logic signed [rpbf_pkg::DIFF_W-1:0]  a,
    input  logic signed [rpbf_pkg::ENTRY_W-1:0] b,
    output logic                                busy,
    output logic signed [rpbf_pkg::ACC_W-1:0]   acc
);
    import rpbf_pkg::*;

    logic                    busy_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] a_sh_reg;
    logic [ENTRY_W-1:0]      b_sh_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        last_reg;
    logic                    neg_reg;
    logic signed [ACC_W-1:0] term;
    logic                    sub;

    // the sign bit of the multiplier carries negative weight
    always_comb begin
        term     = b_sh_reg[0] ? a_sh_reg : '0;
        sub      = neg_reg ^ (cnt_reg == last_reg);
        acc_next = sub ? (acc_reg - term) : (acc_reg + term);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (cmd.start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && (cnt_reg == last_reg)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            case (cmd.init)
                MAC_INIT_ZERO: acc_reg <= '0;
                MAC_INIT_ONE:  acc_reg <= 64'sh1000_0000;
                default:       acc_reg <= acc_reg;
            endcase
            a_sh_reg <= ACC_W'(a);
            b_sh_reg <= b;
            cnt_reg  <= '0;
            last_reg <= cmd.last_bit;
            neg_reg  <= cmd.neg;
        end else if (busy_reg) begin
            acc_reg  <= acc_next;
            a_sh_reg <= a_sh_reg <<< 1;
            b_sh_reg <= {b_sh_reg[ENTRY_W-1], b_sh_reg[ENTRY_W-1:1]};
            cnt_reg  <= cnt_reg + 5'd1;
        end
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

/* rtl/core/relative_pose_body_frame_core.sv */
// relative_pose_body_frame_core: payload position and velocity in the vehicle body frame
//
// input stream: one measurement per transfer, kind in s_tuser (vehicle pose, vehicle
// velocity, payload position, payload velocity, tick). measurements are latched with
// the last received timestamp and a received flag per kind; s_tready is high while idle.
// a tick with all four kinds received starts a computation; an earlier tick, a tick
// during idle with flags missing, or an unused kind is taken and dropped.
// the rotation runs on one bit-serial multiply-accumulate unit: 18 quaternion products
// of 16 bits build the matrix, then 18 entry-by-difference products of 28 bits build
// the six outputs. m_tvalid rises when the sequencer leaves its output state, and
// s_tready returns in that same cycle, so a computed tick holds the input off until
// its result is registered; the serial multiplier bit counts set how long that is.
// output stream: one transfer per computed tick; m_tdata holds until taken. a stalled
// receiver holds the finished result while new measurements are still accepted; the
// next result waits in the core until the output register is free.
// reset clears all flags, zeroes vectors and stamps, and sets identity orientation.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module relative_pose_body_frame_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z, stamp_sec, stamp_nsec, pad
    input  logic [223:0] s_tdata,
    // func
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y, rel_vel_z,
    // out_stamp_sec, out_stamp_nsec, pad
    output logic [255:0] m_tdata
);
    import rpbf_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EISSUE = 3'd1;
    localparam logic [2:0] ST_EWAIT  = 3'd2;
    localparam logic [2:0] ST_OISSUE = 3'd3;
    localparam logic [2:0] ST_OWAIT  = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [VEC_W-1:0]  in_vec [3];
    logic [QUAT_W-1:0] in_qw, in_qx, in_qy, in_qz;
    logic [31:0]       in_sec;
    logic [29:0]       in_nsec;

    logic [2:0]        state_reg;
    logic [VEC_W-1:0]  veh_pos_reg [3];
    logic [VEC_W-1:0]  veh_vel_reg [3];
    logic [VEC_W-1:0]  pay_pos_reg [3];
    logic [VEC_W-1:0]  pay_vel_reg [3];
    logic [QUAT_W-1:0] quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;
    logic [31:0]       latest_sec_reg;
    logic [29:0]       latest_nsec_reg;
    logic [3:0]        seen_reg;
    logic [4:0]        step_reg;
    logic [2:0]        o_reg;
    logic [1:0]        j_reg;
    logic [ENTRY_W-1:0] entry_reg [9];
    logic [VEC_W-1:0]  res_reg [6];
    logic              m_tvalid_reg;
    logic [255:0]      m_tdata_reg;

    logic              in_accept;
    logic              out_free;
    logic              mac_busy;
    logic signed [ACC_W-1:0]   mac_acc;
    mac_cmd_t                  mac_cmd;
    logic signed [DIFF_W-1:0]  mac_a;
    logic signed [ENTRY_W-1:0] mac_b;
    quat_step_t        qs;
    logic [QUAT_W-1:0] qa, qb;
    logic              vel_sel;
    logic [VEC_W-1:0]  pay_val, veh_val;
    logic [1:0]        i_sel;
    logic [3:0]        eidx;

    assign in_vec[0] = s_tdata[31:0];
    assign in_vec[1] = s_tdata[63:32];
    assign in_vec[2] = s_tdata[95:64];
    assign in_qw     = s_tdata[111:96];
    assign in_qx     = s_tdata[127:112];
    assign in_qy     = s_tdata[143:128];
    assign in_qz     = s_tdata[159:144];
    assign in_sec    = s_tdata[191:160];
    assign in_nsec   = s_tdata[221:192];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    function automatic logic [QUAT_W-1:0] quat_pick(input logic [1:0] sel,
                                                    input logic [QUAT_W-1:0] w,
                                                    input logic [QUAT_W-1:0] x,
                                                    input logic [QUAT_W-1:0] y,
                                                    input logic [QUAT_W-1:0] z);
        case (sel)
            Q_W:     return w;
            Q_X:     return x;
            Q_Y:     return y;
            default: return z;
        endcase
    endfunction

    // operand selection for the serial multiplier
    always_comb begin
        qs      = quat_step(step_reg);
        qa      = quat_pick(qs.a_sel, quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg);
        qb      = quat_pick(qs.b_sel, quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg);
        vel_sel = (o_reg >= 3'd3);
        pay_val = vel_sel ? pay_vel_reg[j_reg] : pay_pos_reg[j_reg];
        veh_val = vel_sel ? veh_vel_reg[j_reg] : veh_pos_reg[j_reg];
        i_sel   = vel_sel ? 2'(o_reg - 3'd3) : o_reg[1:0];
        // column i of the matrix, row j: transposed rotation
        eidx    = 4'({j_reg, 1'b0}) + 4'(j_reg) + 4'(i_sel);

        mac_cmd.start = (state_reg == ST_EISSUE) || (state_reg == ST_OISSUE);
        if (state_reg == ST_OISSUE) begin
            mac_a            = {pay_val[VEC_W-1], pay_val} - {veh_val[VEC_W-1], veh_val};
            mac_b            = entry_reg[eidx];
            mac_cmd.neg      = 1'b0;
            mac_cmd.init     = (j_reg == 2'd0) ? MAC_INIT_ZERO : MAC_INIT_KEEP;
            mac_cmd.last_bit = ENTRY_LAST_BIT;
        end else begin
            mac_a            = {{16{qa[QUAT_W-1]}}, qa, 1'b0};
            mac_b            = {{12{qb[QUAT_W-1]}}, qb};
            mac_cmd.neg      = qs.neg;
            mac_cmd.init     = step_reg[0] ? MAC_INIT_KEEP :
                               (qs.one ? MAC_INIT_ONE : MAC_INIT_ZERO);
            mac_cmd.last_bit = QUAT_LAST_BIT;
        end
    end

    rpbf_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .a       (mac_a),
        .b       (mac_b),
        .busy    (mac_busy),
        .acc     (mac_acc)
    );

    // sequencer and latched measurements
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            seen_reg        <= '0;
            quat_w_reg      <= 16'sd16384;
            quat_x_reg      <= '0;
            quat_y_reg      <= '0;
            quat_z_reg      <= '0;
            latest_sec_reg  <= '0;
            latest_nsec_reg <= '0;
            step_reg        <= '0;
            o_reg           <= '0;
            j_reg           <= '0;
            for (int k = 0; k < 3; k++) begin
                veh_pos_reg[k] <= '0;
                veh_vel_reg[k] <= '0;
                pay_pos_reg[k] <= '0;
                pay_vel_reg[k] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        case (s_tuser)
                            FUNC_VEH_POSE: begin
                                veh_pos_reg <= in_vec;
                                quat_w_reg  <= in_qw;
                                quat_x_reg  <= in_qx;
                                quat_y_reg  <= in_qy;
                                quat_z_reg  <= in_qz;
                            end
                            FUNC_VEH_VEL: veh_vel_reg <= in_vec;
                            FUNC_PAY_POS: pay_pos_reg <= in_vec;
                            FUNC_PAY_VEL: pay_vel_reg <= in_vec;
                            default: ;
                        endcase
                        if (s_tuser inside {FUNC_VEH_POSE, FUNC_VEH_VEL,
                                            FUNC_PAY_POS, FUNC_PAY_VEL}) begin
                            latest_sec_reg  <= in_sec;
                            latest_nsec_reg <= in_nsec;
                            seen_reg        <= seen_reg | (4'b0001 << s_tuser[1:0]);
                        end
                        if ((s_tuser == FUNC_TICK) && (seen_reg == 4'hF)) begin
                            step_reg  <= '0;
                            state_reg <= ST_EISSUE;
                        end
                    end
                end
                ST_EISSUE: state_reg <= ST_EWAIT;
                ST_EWAIT: begin
                    if (!mac_busy) begin
                        if (step_reg == ENTRY_LAST_STEP) begin
                            o_reg     <= '0;
                            j_reg     <= '0;
                            state_reg <= ST_OISSUE;
                        end else begin
                            step_reg  <= step_reg + 5'd1;
                            state_reg <= ST_EISSUE;
                        end
                    end
                end
                ST_OISSUE: state_reg <= ST_OWAIT;
                ST_OWAIT: begin
                    if (!mac_busy) begin
                        if (j_reg == 2'd2) begin
                            j_reg <= '0;
                            if (o_reg == 3'd5) begin
                                state_reg <= ST_OUT;
                            end else begin
                                o_reg     <= o_reg + 3'd1;
                                state_reg <= ST_OISSUE;
                            end
                        end else begin
                            j_reg     <= j_reg + 2'd1;
                            state_reg <= ST_OISSUE;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // matrix entries and finished sums
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_EWAIT) && !mac_busy && step_reg[0]) begin
            entry_reg[step_reg[4:1]] <= entry_round_sat(mac_acc);
        end
        if ((state_reg == ST_OWAIT) && !mac_busy && (j_reg == 2'd2)) begin
            res_reg[o_reg] <= out_round_sat(mac_acc);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == ST_OUT) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_OUT) && out_free) begin
            m_tdata_reg <= {2'b00, latest_nsec_reg, latest_sec_reg,
                            res_reg[5], res_reg[4], res_reg[3],
                            res_reg[2], res_reg[1], res_reg[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_PROP(a_idle_mac_quiet, aclk, aresetn, !(s_tready && mac_busy),
                 "mac busy while idle")
    `ASSERT_PROP(a_tick_starts, aclk, aresetn,
                 (in_accept && (s_tuser == FUNC_TICK) && (seen_reg == 4'hF))
                 |=> (state_reg == ST_EISSUE),
                 "full tick did not start")
    `ASSERT_IMPL(a_out_from_seq, aclk, aresetn, $rose(m_tvalid),
                 $past(state_reg == ST_OUT), "result without finished sequence")
    `ASSERT_IMPL(a_seen_sticky, aclk, aresetn, $past(aresetn),
                 (seen_reg & $past(seen_reg)) == $past(seen_reg), "received flag cleared")

endmodule

`default_nettype wire
